### rtl/msr_pkg.sv
// msr_pkg: widths and register indexes for the modulus switch rounding block
// depends on nothing; imported by modulus_switch_round
package msr_pkg;

  localparam int COEFF_WIDTH = 61;
  localparam int HALF_W      = (COEFF_WIDTH + 1) / 2;
  localparam int NUM_W       = 2 * COEFF_WIDTH + 1;
  localparam int QUO_W       = (NUM_W < 64) ? NUM_W : 64;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_MODULUS = 1'b1;

endpackage

### rtl/modulus_switch_round.sv
// modulus_switch_round: rescales a coefficient from modulus q1 to q2 with rounding
// pipelined split multiplier, one restoring division step per stage, final correction
// depends on msr_pkg
//
//  channel  | ports                                    | direction
//  input    | in_valid, in_stall, in_coefficient_in    | into block
//  result   | out_valid, out_stall, out_coefficient_out| out of block
//  config   | cfg_wr_en, cfg_index, cfg_data           | into block
//
// one transfer per cycle while the result is not stalled (123 division steps at 61 bits)
// the depth is set by the division, one quotient bit per register stage
// rst_n is synchronous and clears every valid bit; moduli reset to 2
// a stall on the result holds the whole pipeline while out_valid is high, and in_stall follows it
module modulus_switch_round
  import msr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COEFF_WIDTH-1:0] in_coefficient_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COEFF_WIDTH-1:0] out_coefficient_out,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COEFF_WIDTH-1:0] cfg_data
);

  logic [COEFF_WIDTH-1:0] q1_r, q2_r;
  logic                   en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r <= COEFF_WIDTH'(2);
      q2_r <= COEFF_WIDTH'(2);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SOURCE_MODULUS: q1_r <= cfg_data;
        REG_TARGET_MODULUS: q2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage 1: four partial products
  logic [HALF_W-1:0]   m_lo, m_hi, b_lo, b_hi;
  logic [2*HALF_W-1:0] ll_r, lh_r, hl_r, hh_r;
  logic                v1_r;

  assign m_lo = in_coefficient_in[HALF_W-1:0];
  assign m_hi = HALF_W'(in_coefficient_in[COEFF_WIDTH-1:HALF_W]);
  assign b_lo = q2_r[HALF_W-1:0];
  assign b_hi = HALF_W'(q2_r[COEFF_WIDTH-1:HALF_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= m_lo * b_lo;
      lh_r <= m_lo * b_hi;
      hl_r <= m_hi * b_lo;
      hh_r <= m_hi * b_hi;
    end
  end

  // stage 2: low and middle terms, rounding constant
  logic [NUM_W-1:0]       acc_r;
  logic [2*HALF_W-1:0]    hh2_r;
  logic [COEFF_WIDTH-1:0] half_r;
  logic [COEFF_WIDTH:0]   q1_inc;
  logic                   v2_r;

  assign q1_inc = {1'b0, q1_r} + (COEFF_WIDTH+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r  <= NUM_W'(ll_r) + (NUM_W'(lh_r) << HALF_W) + (NUM_W'(hl_r) << HALF_W);
      hh2_r  <= hh_r;
      half_r <= q1_inc[COEFF_WIDTH:1];
    end
  end

  // stage 3 feeds the division chain at slot 0
  logic [NUM_W-1:0]       dn_r   [NUM_W+1];
  logic [COEFF_WIDTH-1:0] drem_r [NUM_W+1];
  logic                   dv_r   [NUM_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_r[0]   <= acc_r + (NUM_W'(hh2_r) << (2*HALF_W)) + NUM_W'(half_r);
      drem_r[0] <= '0;
    end
  end

  // restoring division, quotient bits shifted in behind the dividend
  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [COEFF_WIDTH:0] trial;
    logic [COEFF_WIDTH:0] diff;
    logic                 ge;

    assign trial = {drem_r[k], dn_r[k][NUM_W-1]};
    assign ge    = trial >= {1'b0, q1_r};
    assign diff  = trial - {1'b0, q1_r};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dn_r[k+1]   <= {dn_r[k][NUM_W-2:0], ge};
        drem_r[k+1] <= ge ? diff[COEFF_WIDTH-1:0] : trial[COEFF_WIDTH-1:0];
      end
    end
  end

  // final correction into the output register
  logic [QUO_W-1:0]       quo, quo_sub;
  logic                   quo_ge;
  logic [COEFF_WIDTH-1:0] res_nxt, out_coeff_r;

  assign quo     = dn_r[NUM_W][QUO_W-1:0];
  assign quo_ge  = quo >= QUO_W'(q2_r);
  assign quo_sub = quo - QUO_W'(q2_r);

  always_comb begin
    if (q1_r == '0) begin
      res_nxt = '0;
    end else if (quo_ge) begin
      res_nxt = quo_sub[COEFF_WIDTH-1:0];
    end else begin
      res_nxt = quo[COEFF_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_coeff_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_coefficient_out = out_coeff_r;

  // checks
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted item did not enter stage one");

  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(v2_r) && $stable(dv_r[0]) && $stable(dv_r[NUM_W])))
    else $error("pipeline moved during a stall");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_coefficient_out)))
    else $error("stalled result changed");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[NUM_W] && !in_stall) |=> out_valid)
    else $error("item lost at the output register");

endmodule
